// ===== rtl/core/gccb_pkg.sv =====
package gccb_pkg;

  // Width of one vertex bit set and of a vertex number
  localparam int unsigned SET_W   = 64;
  localparam int unsigned VID_W   = 6;
  localparam int unsigned COUNT_W = 7;

  // Depth of the queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Input command codes
  localparam logic CMD_ROW_WRITE = 1'b0;
  localparam logic CMD_QUERY     = 1'b1;

  // Work codes handed from front to back
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_PASS
  } op_t;

  // One queued item: data carries the row bits or the candidate set
  typedef struct packed {
    op_t                op;
    logic [VID_W-1:0]   row_idx;
    logic [SET_W-1:0]   data;
    logic [COUNT_W-1:0] limit;
  } item_t;

  // Number of the lowest set bit (63 for an all-zero word)
  function automatic logic [VID_W-1:0] lowest_bit(input logic [SET_W-1:0] v);
    logic [VID_W-1:0] idx;
    idx = VID_W'(SET_W - 1);
    for (int i = SET_W - 1; i >= 0; i--) begin
      if (v[i]) idx = VID_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/gccb_front.sv =====
module gccb_front #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          accept,
  input  logic                          cmd,
  input  logic [gccb_pkg::VID_W-1:0]    row_index,
  input  logic [gccb_pkg::SET_W-1:0]    row_bits,
  input  logic [gccb_pkg::SET_W-1:0]    candidate_set,
  input  logic [gccb_pkg::COUNT_W-1:0]  color_limit,
  output logic                          enq,
  output gccb_pkg::item_t               item
);

  localparam int unsigned NV = (MAX_VERTICES < gccb_pkg::SET_W) ?
                               MAX_VERTICES : gccb_pkg::SET_W;
  localparam logic [gccb_pkg::SET_W-1:0] VMASK = (NV >= gccb_pkg::SET_W) ?
      {gccb_pkg::SET_W{1'b1}} :
      ((gccb_pkg::SET_W'(1) << NV) - gccb_pkg::SET_W'(1));

  logic pruning_en_r;
  logic row_in_range;

  // Pruning enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pruning_en_r <= 1'b1;
    end else if (cfg_we) begin
      pruning_en_r <= cfg_wdata;
    end
  end

  assign row_in_range = ({1'b0, row_index} < (gccb_pkg::VID_W + 1)'(NV));

  // Classify: out-of-range row writes are dropped here
  always_comb begin
    item.row_idx = row_index;
    item.limit   = color_limit;
    if (cmd == gccb_pkg::CMD_ROW_WRITE) begin
      item.op   = gccb_pkg::OP_WRITE;
      item.data = row_bits & VMASK;
      enq       = accept && row_in_range;
    end else begin
      item.op   = pruning_en_r ? gccb_pkg::OP_QUERY : gccb_pkg::OP_PASS;
      item.data = candidate_set & VMASK;
      enq       = accept;
    end
  end

endmodule

// ===== rtl/core/gccb_queue.sv =====
module gccb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            enq,
  input  gccb_pkg::item_t enq_item,
  output logic            full,
  input  logic            deq,
  output gccb_pkg::item_t head,
  output logic            empty
);

  gccb_pkg::item_t                  slot_r [gccb_pkg::QDEPTH];
  logic [gccb_pkg::QPTR_W-1:0]      wptr_r;
  logic [gccb_pkg::QPTR_W-1:0]      rptr_r;
  logic [gccb_pkg::QCNT_W-1:0]      cnt_r;
  logic                             do_enq;
  logic                             do_deq;

  assign full   = (cnt_r == gccb_pkg::QCNT_W'(gccb_pkg::QDEPTH));
  assign empty  = (cnt_r == '0);
  assign do_enq = enq && !full;
  assign do_deq = deq && !empty;
  assign head   = slot_r[rptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_enq) wptr_r <= wptr_r + 1'b1;
      if (do_deq) rptr_r <= rptr_r + 1'b1;
      if (do_enq && !do_deq) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_deq && !do_enq) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_enq) slot_r[wptr_r] <= enq_item;
  end

endmodule

// ===== rtl/core/gccb_back.sv =====
module gccb_back #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gccb_pkg::item_t               q_item,
  input  logic                          q_empty,
  output logic                          q_deq,
  output logic                          out_vld,
  output logic [gccb_pkg::COUNT_W-1:0]  out_count,
  input  logic                          out_pop
);

  localparam int unsigned NV = (MAX_VERTICES < gccb_pkg::SET_W) ?
                               MAX_VERTICES : gccb_pkg::SET_W;
  localparam int unsigned IW = $clog2(NV);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                          state_r;
  logic [gccb_pkg::SET_W-1:0]      avail_r;
  logic [gccb_pkg::SET_W-1:0]      uncol_r;
  logic [gccb_pkg::COUNT_W-1:0]    colors_r;
  logic [gccb_pkg::COUNT_W-1:0]    limit_r;
  logic                            pend_r;
  logic                            out_vld_r;
  logic [gccb_pkg::COUNT_W-1:0]    out_cnt_r;

  // Adjacency rows; a row not yet written reads as zero
  logic [gccb_pkg::SET_W-1:0]      mem [NV];
  logic [NV-1:0]                   row_vld_r;
  logic [gccb_pkg::SET_W-1:0]      rd_row_r;
  logic                            rd_vld_r;

  logic [gccb_pkg::SET_W-1:0]      row_eff;
  logic [gccb_pkg::SET_W-1:0]      avail_eff;
  logic [gccb_pkg::SET_W-1:0]      src;
  logic [gccb_pkg::SET_W-1:0]      pick_bit;
  logic [gccb_pkg::VID_W-1:0]      pick;
  logic [IW-1:0]                   rd_addr;
  logic [IW-1:0]                   wr_addr;
  logic                            cls_end;
  logic                            finish;
  logic                            slot_free;
  logic                            res_load;
  logic                            rd_en;
  logic                            wr_en;

  // Apply the row of last cycle's pick, then pick the lowest vertex left
  assign row_eff   = rd_vld_r ? rd_row_r : '0;
  assign avail_eff = pend_r ? (avail_r & ~row_eff) : avail_r;
  assign cls_end   = (avail_eff == '0);
  assign finish    = cls_end && ((uncol_r == '0) || (colors_r >= limit_r));
  assign src       = cls_end ? uncol_r : avail_eff;
  assign pick      = gccb_pkg::lowest_bit(src);
  assign pick_bit  = gccb_pkg::SET_W'(1) << pick;
  assign rd_addr   = pick[IW-1:0];
  assign wr_addr   = q_item.row_idx[IW-1:0];

  assign slot_free = !out_vld_r || out_pop;
  assign rd_en     = (state_r == S_RUN) && !finish;
  assign wr_en     = (state_r == S_IDLE) && !q_empty && (q_item.op == gccb_pkg::OP_WRITE);

  // A new result enters the output register this cycle
  assign res_load  = ((state_r == S_IDLE) && q_deq && (q_item.op == gccb_pkg::OP_PASS)) ||
                     ((state_r == S_RUN) && finish && slot_free);

  // Dequeue decision
  always_comb begin
    q_deq = 1'b0;
    if ((state_r == S_IDLE) && !q_empty) begin
      case (q_item.op)
        gccb_pkg::OP_WRITE: q_deq = 1'b1;
        gccb_pkg::OP_QUERY: q_deq = 1'b1;
        gccb_pkg::OP_PASS:  q_deq = slot_free;
        default:            q_deq = 1'b1;
      endcase
    end
  end

  // Row memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= q_item.data;
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
      rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
      row_vld_r <= '0;
    end else begin
      if (out_pop && !res_load) out_vld_r <= 1'b0;
      if (wr_en) row_vld_r[wr_addr] <= 1'b1;
      case (state_r)
        S_IDLE: begin
          if (q_deq && (q_item.op == gccb_pkg::OP_QUERY)) begin
            uncol_r  <= q_item.data;
            avail_r  <= '0;
            colors_r <= '0;
            limit_r  <= q_item.limit;
            pend_r   <= 1'b0;
            state_r  <= S_RUN;
          end else if (q_deq && (q_item.op == gccb_pkg::OP_PASS)) begin
            out_cnt_r <= q_item.limit;
            out_vld_r <= 1'b1;
          end
        end
        S_RUN: begin
          if (finish) begin
            if (slot_free) begin
              out_cnt_r <= colors_r;
              out_vld_r <= 1'b1;
              pend_r    <= 1'b0;
              state_r   <= S_IDLE;
            end
          end else begin
            if (cls_end) colors_r <= colors_r + 1'b1;
            avail_r <= src & ~pick_bit;
            uncol_r <= uncol_r & ~pick_bit;
            pend_r  <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_vld   = out_vld_r;
  assign out_count = out_cnt_r;

endmodule

// ===== rtl/core/greedy_coloring_clique_bound_core.sv =====
// A query with pruning on colors at most 64 vertices in the back end, one pick at
// a time, each pick paced by the registered read of the adjacency row memory.
// Items pass through the queue to the back end; a query's result is registered.
// Synchronous active-low reset clears all rows and the queue and sets pruning to 1.
module greedy_coloring_clique_bound_core #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_cmd,
  input  logic [gccb_pkg::VID_W-1:0]    in_row_index,
  input  logic [gccb_pkg::SET_W-1:0]    in_row_bits,
  input  logic [gccb_pkg::SET_W-1:0]    in_candidate_set,
  input  logic [gccb_pkg::COUNT_W-1:0]  in_color_limit,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [gccb_pkg::COUNT_W-1:0]  out_color_count
);

  gccb_pkg::item_t enq_item;
  gccb_pkg::item_t head;
  logic            enq;
  logic            q_full;
  logic            q_empty;
  logic            q_deq;
  logic            out_vld;

  assign in_full   = q_full;
  assign out_empty = !out_vld;

  // Front: classify and mask
  gccb_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .accept        (in_push && !q_full),
    .cmd           (in_cmd),
    .row_index     (in_row_index),
    .row_bits      (in_row_bits),
    .candidate_set (in_candidate_set),
    .color_limit   (in_color_limit),
    .enq           (enq),
    .item          (enq_item)
  );

  // Queue between front and back
  gccb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .enq      (enq),
    .enq_item (enq_item),
    .full     (q_full),
    .deq      (q_deq),
    .head     (head),
    .empty    (q_empty)
  );

  // Back: row memory and coloring sequencer
  gccb_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (head),
    .q_empty   (q_empty),
    .q_deq     (q_deq),
    .out_vld   (out_vld),
    .out_count (out_color_count),
    .out_pop   (out_pop)
  );

endmodule

// ===== rtl/core/gccb_checker.sv =====
module gccb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_push,
  input logic                          in_full,
  input logic                          out_empty,
  input logic                          out_pop,
  input logic [gccb_pkg::COUNT_W-1:0]  out_color_count
);

  // Reset leaves no result and room for input
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("result or full flag present after reset");

  // Without any input after reset, no result can appear
  a_no_spurious: assert property (@(posedge clk)
    !rst_n ##1 (rst_n && !in_push) |=> out_empty)
    else $error("result appeared with no item pushed");

  // A waiting result holds until popped
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_color_count)))
    else $error("waiting result changed or vanished");

endmodule

bind greedy_coloring_clique_bound_core gccb_checker u_gccb_checker (.*);

// ===== sim/gccb_bound_checker.sv =====
module gccb_bound_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_push,
  input  logic                          in_full,
  input  logic                          in_cmd,
  input  logic [gccb_pkg::VID_W-1:0]    in_row_index,
  input  logic [gccb_pkg::SET_W-1:0]    in_row_bits,
  input  logic [gccb_pkg::SET_W-1:0]    in_candidate_set,
  input  logic [gccb_pkg::COUNT_W-1:0]  in_color_limit,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  logic [gccb_pkg::COUNT_W-1:0]  out_color_count,
  output int unsigned                   bound_pending,
  output int unsigned                   mismatch_total
);

  localparam int unsigned SET_W      = gccb_pkg::SET_W;
  localparam int unsigned COUNT_W    = gccb_pkg::COUNT_W;
  localparam int unsigned REPORT_MAX = 10;

  // Shadow of the adjacency matrix and the pruning switch
  logic [SET_W-1:0]   adj_rows [SET_W];
  logic               prune_on;
  logic [COUNT_W-1:0] expected_counts [$];
  int unsigned        errors;

  // Greedy split of the set into independent classes, lowest vertex first, up to the limit
  function automatic logic [COUNT_W-1:0] greedy_class_count(
    input logic [SET_W-1:0]   vset,
    input logic [COUNT_W-1:0] limit
  );
    logic [SET_W-1:0] uncolored;
    logic [SET_W-1:0] avail;
    int unsigned      classes;
    int unsigned      v;
    uncolored = vset;
    classes   = 0;
    while (uncolored != '0 && classes < limit) begin
      classes++;
      avail = uncolored;
      while (avail != '0) begin
        v = 0;
        while (!avail[v]) v++;
        avail[v]     = 1'b0;
        uncolored[v] = 1'b0;
        // only the picked vertex's own row knocks out neighbors
        avail = avail & ~adj_rows[v];
      end
    end
    return COUNT_W'(classes);
  endfunction

  function automatic void note_error(input string msg);
    if (errors < REPORT_MAX) $display("%s", msg);
    errors++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (adj_rows[i]) adj_rows[i] = '0;
      prune_on = 1'b1;
      expected_counts.delete();
    end else begin
      // result side: compare with the oldest expectation
      if (out_pop && !out_empty) begin
        if (expected_counts.size() == 0) begin
          note_error($sformatf("unexpected result: color_count %0d, nothing pending",
                               out_color_count));
        end else begin
          if (out_color_count !== expected_counts[0])
            note_error($sformatf("mismatch: color_count expected %0d, got %0d",
                                 expected_counts[0], out_color_count));
          void'(expected_counts.pop_front());
        end
      end

      // input side: update rows or predict a bound
      if (in_push && !in_full) begin
        if (in_cmd == gccb_pkg::CMD_ROW_WRITE) begin
          adj_rows[in_row_index] = in_row_bits;
        end else if (!prune_on) begin
          expected_counts.insert(expected_counts.size(), in_color_limit);
        end else begin
          expected_counts.insert(expected_counts.size(),
                                 greedy_class_count(in_candidate_set, in_color_limit));
        end
      end

      // a register write takes effect for items after this edge
      if (cfg_we) prune_on = cfg_wdata;
    end
    bound_pending  <= expected_counts.size();
    mismatch_total <= errors;
  end

endmodule

// ===== sim/tb_greedy_coloring_clique_bound_core.sv =====
module tb_greedy_coloring_clique_bound_core;

  localparam int unsigned VID_W         = gccb_pkg::VID_W;
  localparam int unsigned SET_W         = gccb_pkg::SET_W;
  localparam int unsigned COUNT_W       = gccb_pkg::COUNT_W;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned LONG_HOLD    = 600;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_wdata;
  logic                in_push;
  logic                in_full;
  logic                in_cmd;
  logic [VID_W-1:0]    in_row_index;
  logic [SET_W-1:0]    in_row_bits;
  logic [SET_W-1:0]    in_candidate_set;
  logic [COUNT_W-1:0]  in_color_limit;
  logic                out_empty;
  logic                out_pop;
  logic [COUNT_W-1:0]  out_color_count;

  int unsigned bound_pending;
  int unsigned mismatch_total;
  int unsigned idle_cycles;
  int unsigned pop_stall;
  int unsigned results_taken;
  logic        long_hold_done;
  logic        rush;

  greedy_coloring_clique_bound_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_cmd           (in_cmd),
    .in_row_index     (in_row_index),
    .in_row_bits      (in_row_bits),
    .in_candidate_set (in_candidate_set),
    .in_color_limit   (in_color_limit),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_color_count  (out_color_count)
  );

  gccb_bound_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_cmd           (in_cmd),
    .in_row_index     (in_row_index),
    .in_row_bits      (in_row_bits),
    .in_candidate_set (in_candidate_set),
    .in_color_limit   (in_color_limit),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_color_count  (out_color_count),
    .bound_pending    (bound_pending),
    .mismatch_total   (mismatch_total)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_gap(input logic no_idle);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Vertex set of varied density
  function automatic logic [SET_W-1:0] vertex_set();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0: return '0;
      1: return '1;
      2, 3, 4: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      5, 6: return {$urandom, $urandom};
      7, 8: return {$urandom, $urandom} | {$urandom, $urandom};
      default: return SET_W'(1) << $urandom_range(0, SET_W - 1);
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] color_cap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return COUNT_W'($urandom_range(64, 127));
    if (r < 8) return COUNT_W'($urandom_range(0, 127));
    return COUNT_W'($urandom_range(0, 8));
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(
    input logic               cmd,
    input logic [VID_W-1:0]   row,
    input logic [SET_W-1:0]   bits,
    input logic [SET_W-1:0]   vset,
    input logic [COUNT_W-1:0] limit
  );
    int unsigned gap;
    gap = idle_gap(rush);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push          <= 1'b1;
    in_cmd           <= cmd;
    in_row_index     <= row;
    in_row_bits      <= bits;
    in_candidate_set <= vset;
    in_color_limit   <= limit;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic write_row(input logic [VID_W-1:0] row, input logic [SET_W-1:0] bits);
    send_item(gccb_pkg::CMD_ROW_WRITE, row, bits, {$urandom, $urandom}, COUNT_W'($urandom));
  endtask

  task automatic ask_bound(input logic [SET_W-1:0] vset, input logic [COUNT_W-1:0] limit);
    send_item(gccb_pkg::CMD_QUERY, VID_W'($urandom), {$urandom, $urandom}, vset, limit);
  endtask

  // Let every result drain, then let a trailing row write finish
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (bound_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pruning(input logic on);
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_items(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      rush = ((k / 100) % 3) == 2;
      if ($urandom_range(0, 9) < 3)
        write_row(VID_W'($urandom), vertex_set());
      else
        ask_bound(vertex_set(), color_cap());
    end
    rush = 1'b0;
  endtask

  // Result side: random pops, one long hold once results are flowing
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop        <= 1'b0;
      pop_stall      <= 0;
      results_taken  <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_pop && !out_empty) results_taken <= results_taken + 1;
      if (!long_hold_done && results_taken == 150) begin
        long_hold_done <= 1'b1;
        out_pop        <= 1'b0;
        pop_stall      <= LONG_HOLD;
      end else if (pop_stall != 0) begin
        out_pop   <= 1'b0;
        pop_stall <= pop_stall - 1;
      end else if (out_pop && !out_empty) begin
        int unsigned g;
        g = idle_gap(rush);
        if (g == 0) begin
          out_pop <= 1'b1;
        end else begin
          out_pop   <= 1'b0;
          pop_stall <= g - 1;
        end
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted item or taken result
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_push          = 1'b0;
    in_cmd           = gccb_pkg::CMD_ROW_WRITE;
    in_row_index     = '0;
    in_row_bits      = '0;
    in_candidate_set = '0;
    in_color_limit   = '0;
    rush             = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_pruning(1'b1);

    // directed: empty graph, empty set, zero and oversized limits
    ask_bound('0, COUNT_W'(64));
    ask_bound('1, COUNT_W'(64));
    ask_bound('1, COUNT_W'(0));
    ask_bound(SET_W'(1) << 63, COUNT_W'(1));
    // hub vertices at both ends of the row range
    write_row(VID_W'(0), '1);
    write_row(VID_W'(63), '1);
    ask_bound('1, COUNT_W'(127));
    ask_bound('1, COUNT_W'(1));
    // clique on vertices 0..7
    for (int unsigned r = 0; r < 8; r++) write_row(VID_W'(r), SET_W'(8'hFF));
    ask_bound(SET_W'(8'hFF), COUNT_W'(64));
    ask_bound(SET_W'(8'hFF), COUNT_W'(5));
    // one-sided edge: 10 sees 11, 11 does not see 10
    write_row(VID_W'(10), SET_W'(1) << 11);
    ask_bound((SET_W'(1) << 10) | (SET_W'(1) << 11), COUNT_W'(64));
    settle();

    // directed with pruning off: limit comes back as given
    set_pruning(1'b0);
    ask_bound('1, COUNT_W'(127));
    ask_bound('0, COUNT_W'(0));
    write_row(VID_W'(5), '1);
    ask_bound({$urandom, $urandom}, COUNT_W'(64));
    settle();

    // random phases across both pruning settings
    set_pruning(1'b1);
    random_items(500);
    settle();
    set_pruning(1'b0);
    random_items(100);
    settle();
    set_pruning(1'b1);
    random_items(300);
    settle();

    if (mismatch_total == 0 && bound_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/gccb_pkg.sv
rtl/core/gccb_front.sv
rtl/core/gccb_queue.sv
rtl/core/gccb_back.sv
rtl/core/greedy_coloring_clique_bound_core.sv
rtl/core/gccb_checker.sv
sim/gccb_bound_checker.sv
sim/tb_greedy_coloring_clique_bound_core.sv
